// ===== rtl/core/grpt_pkg.sv =====
// ----------------------------------------------------------------------------
// grpt_pkg
// Shared types and constants for the grid rectangle placement table.
// ----------------------------------------------------------------------------
`default_nettype none
package grpt_pkg;
  localparam int unsigned MaxEntriesDef = 16;
  localparam int unsigned MaxGridDef    = 16;
  localparam int unsigned TagBitsDef    = 16;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_MOVE   = 2'd1,
    CMD_ROTATE = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FIT   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  localparam logic [0:0] REG_COLS = 1'b0;
  localparam logic [0:0] REG_ROWS = 1'b1;
endpackage
`default_nettype wire

// ===== rtl/core/grpt_store.sv =====
// ----------------------------------------------------------------------------
// grpt_store
// Entry memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module grpt_store #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 35
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/core/grid_rectangle_placement_table.sv =====
// ----------------------------------------------------------------------------
// grid_rectangle_placement_table
// First-fit rectangle placement with rotation, entries kept in a memory.
// ----------------------------------------------------------------------------
// Every command runs through a sequencer around one memory with a registered
// read port, one entry read per cycle. A lookup for move, rotate or remove
// walks the entries up to the first tag match. An add tests each candidate
// (slot, orientation) by sweeping all N stored entries, and there are up to
// 2*rows*cols candidates. Move and rotate run one sweep after the lookup;
// remove shifts the tail down one entry at a time, reading entry k+1 and
// then writing it to k. The result word is held in an output register
// and the next word is taken once it is gone. No clearing pass after reset.
`default_nettype none
module grid_rectangle_placement_table #(
  parameter int unsigned MAX_ENTRIES = grpt_pkg::MaxEntriesDef,
  parameter int unsigned MAX_GRID    = grpt_pkg::MaxGridDef,
  parameter int unsigned TAG_BITS    = grpt_pkg::TagBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // {command, item_tag, item_width, item_height, target_x, target_y}, low bit up
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [39:0] s_axis_tdata_i,
  // {status, result_x, result_y, result_rotated, result_width, result_height},
  // low bit up
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned TW = (TAG_BITS < 16) ? TAG_BITS : 16;
  localparam int unsigned EW = TW + 4 + 4 + 5 + 5 + 1;
  localparam logic [4:0] GridMax = (MAX_GRID > 16) ? 5'd16 : 5'(MAX_GRID);

  localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_FIND = 3'd2,
                         S_CHK = 3'd3, S_SHIFT = 3'd4, S_OUT = 3'd5;

  // config registers
  logic [4:0] cols_q, rows_q;
  logic       wr_en;
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= 5'd8;
      rows_q <= 5'd8;
    end else if (wr_en && paddr[2] == grpt_pkg::REG_COLS && paddr[1:0] == 2'b00) begin
      cols_q <= pwdata[4:0];
    end else if (wr_en && paddr[2] == grpt_pkg::REG_ROWS && paddr[1:0] == 2'b00) begin
      rows_q <= pwdata[4:0];
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr == {grpt_pkg::REG_COLS, 2'b00}) prdata[4:0] = cols_q;
    else if (paddr == {grpt_pkg::REG_ROWS, 2'b00}) prdata[4:0] = rows_q;
  end

  logic [4:0] ecols, erows;
  assign ecols = (cols_q > GridMax) ? GridMax : cols_q;
  assign erows = (rows_q > GridMax) ? GridMax : rows_q;

  // command registers
  logic [2:0]    st_q;
  logic [1:0]    cmd_q;
  logic [TW-1:0] tag_q;
  logic [4:0]    w_q, h_q;
  logic [3:0]    tx_q, ty_q;
  logic [CW-1:0] cnt_q;
  logic [CW-1:0] idx_q;      // entry being issued
  logic          rv_q;       // read data valid this cycle
  logic          rv_d;
  logic          rlast_q;
  logic [IW-1:0] k_q;        // found index
  logic [4:0]    cx_q, cy_q; // candidate position
  logic          cr_q;       // candidate rotation
  logic          hit_q;      // overlap seen in sweep
  logic [EW-1:0] ent_q;      // found entry
  logic [23:0]   res_q;
  logic          ph_q;       // shift phase

  // memory
  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  grpt_store #(.Depth(MAX_ENTRIES), .Width(EW)) u_store (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // entry fields: {turned, tall, wide, row, col, tag}
  logic [TW-1:0] r_tag;
  logic [3:0]    r_col, r_row;
  logic [4:0]    r_wide, r_tall, r_w, r_h;
  logic          r_turn;
  assign {r_turn, r_tall, r_wide, r_row, r_col, r_tag} = rdata;
  assign r_w = r_turn ? r_tall : r_wide;
  assign r_h = r_turn ? r_wide : r_tall;

  // candidate geometry
  logic [4:0] cw, ch;
  logic [5:0] cxe, cye, rxe, rye;
  logic       inb, ovl, skip;
  assign cw  = cr_q ? h_q : w_q;
  assign ch  = cr_q ? w_q : h_q;
  assign cxe = {1'b0, cx_q} + {1'b0, cw};
  assign cye = {1'b0, cy_q} + {1'b0, ch};
  assign rxe = {2'b0, r_col} + {1'b0, r_w};
  assign rye = {2'b0, r_row} + {1'b0, r_h};
  assign inb = (cxe <= {1'b0, ecols}) && (cye <= {1'b0, erows});
  assign skip = (cmd_q != grpt_pkg::CMD_ADD) && (r_tag == tag_q);
  assign ovl = !skip && ({1'b0, cx_q} < rxe) && (cxe > {2'b0, r_col}) &&
               ({1'b0, cy_q} < rye) && (cye > {2'b0, r_row});

  logic idle_acc;
  assign s_axis_tready_o = (st_q == S_IDLE) && !m_axis_tvalid_o;
  assign idle_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tdata_o = res_q;

  logic [IW-1:0] idx_n;
  assign idx_n = idx_q[IW-1:0];
  assign raddr = (st_q == S_SHIFT) ? IW'(k_q + 1'b1) : idx_n;

  // read issue: lookup until a match, sweep until the last entry
  always_comb begin
    rv_d = 1'b0;
    if (st_q == S_FIND) rv_d = !(rv_q && r_tag == tag_q) && (idx_q < cnt_q);
    else if (st_q == S_CHK) rv_d = (idx_q < cnt_q) && !(rv_q && rlast_q);
  end

  // sweep end and fit decision
  logic done_sweep, fitok, chk_end;
  assign done_sweep = rv_q && rlast_q;
  assign fitok = inb && !hit_q && !(rv_q && ovl);
  assign chk_end = (st_q == S_CHK) && (done_sweep || cnt_q == '0);

  // entry written on success
  logic [EW-1:0] new_ent;
  assign new_ent = (cmd_q == grpt_pkg::CMD_ADD) ?
    {cr_q, h_q, w_q, cy_q[3:0], cx_q[3:0], tag_q} :
    {cr_q, ent_q[EW-2 -: 10], cy_q[3:0], cx_q[3:0], tag_q};

  always_comb begin
    we = 1'b0; waddr = k_q; wdata = new_ent;
    if (st_q == S_SHIFT && ph_q) begin
      we = 1'b1; wdata = rdata;
    end else if (chk_end && fitok) begin
      we = 1'b1;
      waddr = (cmd_q == grpt_pkg::CMD_ADD) ? cnt_q[IW-1:0] : k_q;
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; cnt_q <= '0; m_axis_tvalid_o <= 1'b0;
      rv_q <= 1'b0; rlast_q <= 1'b0; ph_q <= 1'b0;
    end else begin
      if (st_q == S_OUT) m_axis_tvalid_o <= 1'b1;
      else if (m_axis_tvalid_o && m_axis_tready_i) m_axis_tvalid_o <= 1'b0;
      rv_q <= rv_d;
      unique case (st_q)
        S_IDLE: if (idle_acc) begin
          cmd_q <= s_axis_tdata_i[1:0];
          tag_q <= s_axis_tdata_i[2 +: TW];
          w_q <= s_axis_tdata_i[22:18]; h_q <= s_axis_tdata_i[27:23];
          tx_q <= s_axis_tdata_i[31:28]; ty_q <= s_axis_tdata_i[35:32];
          idx_q <= '0; hit_q <= 1'b0;
          cx_q <= '0; cy_q <= '0; cr_q <= 1'b0;
          if (s_axis_tdata_i[1:0] == grpt_pkg::CMD_ADD) begin
            if (cnt_q >= CW'(MAX_ENTRIES)) begin
              res_q <= {22'd0, grpt_pkg::ST_FULL}; st_q <= S_OUT;
            end else st_q <= S_SCAN;
          end else st_q <= S_FIND;
        end
        // add: step candidates
        S_SCAN: begin
          if (cy_q >= erows) begin
            res_q <= {22'd0, grpt_pkg::ST_NO_FIT}; st_q <= S_OUT;
          end else if (cx_q >= ecols) begin
            cx_q <= '0; cy_q <= cy_q + 5'd1;
          end else begin
            idx_q <= '0; hit_q <= 1'b0; st_q <= S_CHK;
          end
        end
        // lookup by tag
        S_FIND: begin
          if (rv_q && r_tag == tag_q) begin
            ent_q <= rdata; k_q <= IW'(idx_q - 1'b1);
            if (cmd_q == grpt_pkg::CMD_REMOVE) begin
              res_q <= {3'd0, r_tall, r_wide, r_turn, r_row, r_col, grpt_pkg::ST_OK};
              ph_q <= 1'b0; st_q <= S_SHIFT;
            end else begin
              cx_q <= (cmd_q == grpt_pkg::CMD_MOVE) ? {1'b0, tx_q} : {1'b0, r_col};
              cy_q <= (cmd_q == grpt_pkg::CMD_MOVE) ? {1'b0, ty_q} : {1'b0, r_row};
              cr_q <= r_turn ^ (cmd_q == grpt_pkg::CMD_ROTATE);
              w_q <= r_wide; h_q <= r_tall;
              idx_q <= '0; hit_q <= 1'b0; st_q <= S_CHK;
            end
          end else if (idx_q >= cnt_q) begin
            if (!rv_q) begin
              res_q <= {22'd0, grpt_pkg::ST_NOT_FOUND}; st_q <= S_OUT;
            end
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        // sweep all entries against candidate
        S_CHK: begin
          if (rv_q && ovl) hit_q <= 1'b1;
          if (idx_q < cnt_q && !(rv_q && rlast_q)) begin
            rlast_q <= (idx_q + 1'b1 == cnt_q);
            idx_q <= idx_q + 1'b1;
          end else if (done_sweep || cnt_q == '0) begin
            if (fitok) begin
              if (cmd_q == grpt_pkg::CMD_ADD) cnt_q <= cnt_q + 1'b1;
              res_q <= {13'd0, cr_q, cy_q[3:0], cx_q[3:0], grpt_pkg::ST_OK};
              st_q <= S_OUT;
            end else if (cmd_q == grpt_pkg::CMD_ADD) begin
              if (cr_q) begin cr_q <= 1'b0; cx_q <= cx_q + 5'd1; end
              else cr_q <= 1'b1;
              st_q <= S_SCAN;
            end else begin
              res_q <= {13'd0, ent_q[EW-1], ent_q[TW+4 +: 4], ent_q[TW +: 4],
                        grpt_pkg::ST_NO_FIT};
              st_q <= S_OUT;
            end
          end
        end
        // close the gap: read k+1, write to k
        S_SHIFT: begin
          if (32'(k_q) + 1 >= 32'(cnt_q)) begin
            cnt_q <= cnt_q - 1'b1; st_q <= S_OUT;
          end else if (!ph_q) ph_q <= 1'b1;
          else begin ph_q <= 1'b0; k_q <= k_q + 1'b1; end
        end
        S_OUT: begin
          st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // bits with no use here
  logic unused_ok;
  assign unused_ok = ^{s_axis_tdata_i[39:36], pwdata[31:5], ent_q[TW-1:0]};
endmodule
`default_nettype wire

// ===== rtl/core/grpt_checker.sv =====
// ----------------------------------------------------------------------------
// grpt_port_assert
// Port-level checks on the placement table handshakes.
// ----------------------------------------------------------------------------
`default_nettype none
module grpt_port_assert (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [23:0] m_axis_tdata_o
);
  // result held while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result word changed while stalled");
  // no new word while a result waits
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("accepted while result pending");
  // accepted word does not yield a result next cycle
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !m_axis_tvalid_o)
    else $error("result too early");
endmodule

bind grid_rectangle_placement_table grpt_port_assert u_grpt_port_assert (
  .clk_i, .rst_ni, .s_axis_tvalid_i, .s_axis_tready_o,
  .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o
);
`default_nettype wire
